// ----- rtl/iee_pkg.sv -----
//------------------------------------------------------------------------------
// iee_pkg: shared types and constants of the infix expression evaluator
// Character codes, error codes, sequencer states and the shared-unit command.
//------------------------------------------------------------------------------
package iee_pkg;

	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_ADD   = 8'h2B;
	localparam logic [7:0] CH_SUB   = 8'h2D;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_DIV0   = 2'd1,
		ERR_DEEP   = 2'd2,
		ERR_NOLEFT = 2'd3
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_PUSH,
		ST_ARITH,
		ST_COMMIT,
		ST_OP,
		ST_FINISH,
		ST_FOLD,
		ST_RESULT,
		ST_CLEAR
	} state_t;

	// command to the shared multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} mdu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mdu_stat_t;

endpackage

// ----- rtl/iee_stream_if.sv -----
//------------------------------------------------------------------------------
// iee_stream_if: valid/ready channel
// Carries one payload of parameterized type per beat.
//------------------------------------------------------------------------------
interface iee_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/iee_mdu.sv -----
//------------------------------------------------------------------------------
// iee_mdu: shared iterative multiply/divide unit
// Signed multiply (shift-add) or truncating signed divide (restoring), one bit
// a cycle, then a final step that fixes the sign of the quotient.
//------------------------------------------------------------------------------
module iee_mdu #(
	parameter int W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iee_pkg::mdu_cmd_t    cmd,
	input  logic [W-1:0]         a,
	input  logic [W-1:0]         b,
	output iee_pkg::mdu_stat_t   stat,
	output logic [W-1:0]         result
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic          div_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;    // product or remainder
	logic [W-1:0]  sh_q;     // multiplier bits or dividend/quotient
	logic [W-1:0]  b_q;      // multiplicand or divisor magnitude
	logic [W:0]    trial;
	logic [W-1:0]  ma;
	logic [W-1:0]  mb;

	assign ma    = a[W-1] ? (~a + 1'b1) : a;
	assign mb    = b[W-1] ? (~b + 1'b1) : b;
	assign trial = {acc_q, sh_q[W-1]} - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			div_q <= cmd.is_div;
			if (cmd.is_div) begin
				neg_q <= a[W-1] ^ b[W-1];
				acc_q <= '0;
				sh_q  <= ma;
				b_q   <= mb;
			end else begin
				neg_q <= 1'b0;
				acc_q <= '0;
				sh_q  <= b;
				b_q   <= a;
			end
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				// sign fix of the quotient
				if (div_q && neg_q) sh_q <= ~sh_q + 1'b1;
			end else if (div_q) begin
				if (!trial[W]) begin
					acc_q <= trial[W-1:0];
					sh_q  <= {sh_q[W-2:0], 1'b1};
				end else begin
					acc_q <= {acc_q[W-2:0], sh_q[W-1]};
					sh_q  <= {sh_q[W-2:0], 1'b0};
				end
			end else begin
				if (sh_q[0]) acc_q <= acc_q + b_q;
				sh_q <= sh_q >> 1;
				b_q  <= b_q << 1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = div_q ? sh_q : acc_q;
endmodule

// ----- rtl/iee_frames.sv -----
//------------------------------------------------------------------------------
// iee_frames: per-level frame store
// Sum, last term and pending left operand per nesting level, with valid bits
// so that a level reads as cleared until written.
//------------------------------------------------------------------------------
module iee_frames #(
	parameter int W = 32,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr_all,
	input  logic [$clog2(D)-1:0] lvl,
	input  logic                 we,
	input  logic                 clr_lvl,
	input  logic [W-1:0]         wsum,
	input  logic [W-1:0]         wlast,
	input  logic [W-1:0]         wpend,
	input  logic [3:0]           wflags,
	output logic [W-1:0]         rsum,
	output logic [W-1:0]         rlast,
	output logic [W-1:0]         rpend,
	output logic [3:0]           rflags
);
	// flags: {has_term, op_is_div, sign_neg, multiplying}
	logic [W-1:0] sum_q  [D];
	logic [W-1:0] last_q [D];
	logic [W-1:0] pend_q [D];
	logic [3:0]   flag_q [D];
	logic [D-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr_all) begin
			vld_q <= '0;
		end else if (clr_lvl) begin
			vld_q[lvl] <= 1'b0;
		end else if (we) begin
			vld_q[lvl] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			sum_q[lvl]  <= wsum;
			last_q[lvl] <= wlast;
			pend_q[lvl] <= wpend;
			flag_q[lvl] <= wflags;
		end
	end

	assign rsum   = vld_q[lvl] ? sum_q[lvl]  : '0;
	assign rlast  = vld_q[lvl] ? last_q[lvl] : '0;
	assign rpend  = vld_q[lvl] ? pend_q[lvl] : '0;
	assign rflags = vld_q[lvl] ? flag_q[lvl] : '0;
endmodule

// ----- rtl/infix_expression_evaluator.sv -----
//------------------------------------------------------------------------------
// infix_expression_evaluator: byte-serial infix integer calculator
// Sequencer over a frame store and one shared multiply/divide unit.
//------------------------------------------------------------------------------
// Usage:
//   in  : one beat per ASCII byte {char_byte, is_last}. Digits, + - * / ( ).
//   out : one beat {value, error_code} after the byte marked is_last.
// Steps per accepted byte before in.ready returns:
//   digit: decode only. Other bytes: decode and operator step, with push and
//   commit first when they end a number. ')' above level 0 adds a push, commit
//   and fold to merge the closed level. A term after * or /: the push also runs
//   the bit-serial multiply/divide unit before the commit.
//   last byte: a finish step, then a fold, push and commit per open level (plus
//   a multiply/divide run for a pending * or /) and a fold check; out.valid is
//   set in the result step, and a clear step then clears the frames.
//   One byte at a time: in.ready is low while a byte is in work.
// Reset: all frames read as zero, level 0, no error; the same happens
//   automatically after each result beat.
// Stall: the result is held in an output register until out.ready; no new
//   byte is taken until it leaves.
//------------------------------------------------------------------------------
module infix_expression_evaluator #(
	parameter int MAX_DEPTH   = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	iee_stream_if.sink   in,
	iee_stream_if.source out
);
	localparam int W  = VALUE_WIDTH;
	localparam int LW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	iee_pkg::state_t state_q, state_d;

	logic [7:0]    ch_q;
	logic          last_q;
	logic [W-1:0]  num_q;
	logic          num_act_q;
	logic [LW-1:0] lvl_q;
	logic          stop_q;
	iee_pkg::err_t err_q;
	logic [W-1:0]  opnd_q;    // operand being pushed
	logic          close_q;   // push follows a ')' or fold
	logic [W-1:0]  res_value_q;
	logic [1:0]    res_err_q;
	logic          res_vld_q;

	// frame port
	logic [LW-1:0] f_lvl;
	logic          f_we, f_clr_lvl, f_clr_all;
	logic [W-1:0]  f_wsum, f_wlast, f_wpend, f_rsum, f_rlast, f_rpend;
	logic [3:0]    f_wflags, f_rflags;

	iee_pkg::mdu_cmd_t  m_cmd;
	iee_pkg::mdu_stat_t m_stat;
	logic [W-1:0]       m_res;

	logic is_digit;
	logic [W-1:0] frame_val;
	logic [W-1:0] term;
	logic         has_t, op_div, sgn_neg, mult;

	assign {has_t, op_div, sgn_neg, mult} = f_rflags;
	assign is_digit  = (ch_q >= iee_pkg::CH_ZERO) && (ch_q <= iee_pkg::CH_NINE);
	assign frame_val = has_t ? (f_rsum + f_rlast) : f_rsum;
	assign term      = sgn_neg ? (~opnd_q + 1'b1) : opnd_q;

	iee_frames #(.W(W), .D(MAX_DEPTH)) u_frames (
		.clk, .arst_n, .clr_all(f_clr_all), .lvl(f_lvl), .we(f_we),
		.clr_lvl(f_clr_lvl), .wsum(f_wsum), .wlast(f_wlast), .wpend(f_wpend),
		.wflags(f_wflags), .rsum(f_rsum), .rlast(f_rlast), .rpend(f_rpend),
		.rflags(f_rflags)
	);

	iee_mdu #(.W(W)) u_mdu (
		.clk, .arst_n, .cmd(m_cmd), .a(f_rpend), .b(opnd_q),
		.stat(m_stat), .result(m_res)
	);

	assign f_lvl     = lvl_q;
	assign in.ready  = (state_q == iee_pkg::ST_IDLE) && !res_vld_q;
	assign out.valid = res_vld_q;
	assign out.data  = {res_value_q, res_err_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= iee_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// control: next state and frame writes
	always_comb begin
		state_d   = state_q;
		f_we      = 1'b0;
		f_clr_lvl = 1'b0;
		f_clr_all = 1'b0;
		f_wsum    = f_rsum;
		f_wlast   = f_rlast;
		f_wpend   = f_rpend;
		f_wflags  = f_rflags;
		m_cmd     = '0;
		case (state_q)
			iee_pkg::ST_IDLE: begin
				if (in.valid && in.ready) state_d = iee_pkg::ST_DECODE;
			end
			iee_pkg::ST_DECODE: begin
				if (stop_q)                  state_d = last_q ? iee_pkg::ST_RESULT
				                                            : iee_pkg::ST_IDLE;
				else if (is_digit)           state_d = last_q ? iee_pkg::ST_FINISH
				                                            : iee_pkg::ST_IDLE;
				else if (num_act_q)          state_d = iee_pkg::ST_PUSH;
				else                         state_d = iee_pkg::ST_OP;
			end
			iee_pkg::ST_PUSH: begin
				if (mult) begin
					if (op_div && opnd_q == '0) begin
						state_d = iee_pkg::ST_COMMIT;
					end else begin
						m_cmd.start  = 1'b1;
						m_cmd.is_div = op_div;
						state_d      = iee_pkg::ST_ARITH;
					end
				end else begin
					state_d = iee_pkg::ST_COMMIT;
				end
			end
			iee_pkg::ST_ARITH: begin
				if (m_stat.done) state_d = iee_pkg::ST_COMMIT;
			end
			iee_pkg::ST_COMMIT: begin
				if (!(mult && op_div && opnd_q == '0)) begin
					f_we     = 1'b1;
					f_wsum   = has_t ? (f_rsum + f_rlast) : f_rsum;
					f_wlast  = mult ? m_res : term;
					f_wflags = {1'b1, op_div, sgn_neg, mult};
				end
				if (close_q)     state_d = iee_pkg::ST_FOLD;
				else if (ch_q == 8'h00 && last_q) state_d = iee_pkg::ST_FOLD;
				else             state_d = iee_pkg::ST_OP;
			end
			iee_pkg::ST_OP: begin
				state_d = last_q ? iee_pkg::ST_FINISH : iee_pkg::ST_IDLE;
				if (!stop_q) begin
					case (ch_q)
						iee_pkg::CH_OPEN: begin
							if (32'(lvl_q) + 1 < MAX_DEPTH) f_clr_lvl = 1'b0;
						end
						iee_pkg::CH_CLOSE: begin
							if (lvl_q != '0) begin
								f_clr_lvl = 1'b1;
								state_d   = iee_pkg::ST_PUSH;
							end
						end
						iee_pkg::CH_ADD, iee_pkg::CH_SUB: begin
							f_we     = 1'b1;
							f_wflags = {has_t, op_div, ch_q == iee_pkg::CH_SUB, 1'b0};
						end
						iee_pkg::CH_MUL, iee_pkg::CH_DIV: begin
							if (has_t) begin
								f_we     = 1'b1;
								f_wpend  = f_rlast;
								f_wlast  = '0;
								f_wflags = {1'b0, ch_q == iee_pkg::CH_DIV, sgn_neg, 1'b1};
							end
						end
						default: ;
					endcase
				end
			end
			iee_pkg::ST_FINISH: begin
				if (stop_q)         state_d = iee_pkg::ST_RESULT;
				else if (num_act_q) state_d = iee_pkg::ST_PUSH;
				else                state_d = iee_pkg::ST_FOLD;
			end
			iee_pkg::ST_FOLD: begin
				if (!last_q)                     state_d = iee_pkg::ST_IDLE;
				else if (stop_q || lvl_q == '0)  state_d = iee_pkg::ST_RESULT;
				else begin
					f_clr_lvl = 1'b1;
					state_d   = iee_pkg::ST_PUSH;
				end
			end
			iee_pkg::ST_RESULT: begin
				state_d = iee_pkg::ST_CLEAR;
			end
			iee_pkg::ST_CLEAR: begin
				f_clr_all = 1'b1;
				state_d   = iee_pkg::ST_IDLE;
			end
			default: state_d = iee_pkg::ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q     <= '0;
			num_act_q <= 1'b0;
			lvl_q     <= '0;
			stop_q    <= 1'b0;
			err_q     <= iee_pkg::ERR_NONE;
			close_q   <= 1'b0;
			res_vld_q <= 1'b0;
			last_q    <= 1'b0;
			ch_q      <= '0;
		end else begin
			if (out.valid && out.ready) res_vld_q <= 1'b0;
			case (state_q)
				iee_pkg::ST_IDLE: begin
					if (in.valid && in.ready) begin
						ch_q   <= in.data[8:1];
						last_q <= in.data[0];
					end
				end
				iee_pkg::ST_DECODE: begin
					close_q <= 1'b0;
					if (!stop_q && is_digit) begin
						num_q     <= W'(num_q * W'(10)) + W'(ch_q - iee_pkg::CH_ZERO);
						num_act_q <= 1'b1;
					end else if (!stop_q && num_act_q) begin
						opnd_q    <= num_q;
						num_q     <= '0;
						num_act_q <= 1'b0;
					end
				end
				iee_pkg::ST_PUSH: begin
					if (mult && op_div && opnd_q == '0) begin
						stop_q <= 1'b1;
						if (err_q == iee_pkg::ERR_NONE) err_q <= iee_pkg::ERR_DIV0;
					end
				end
				iee_pkg::ST_COMMIT: begin
					if (close_q) close_q <= 1'b0;
					if (!close_q && last_q && ch_q == 8'h00) ch_q <= 8'h00;
				end
				iee_pkg::ST_OP: begin
					if (!stop_q) begin
						case (ch_q)
							iee_pkg::CH_OPEN: begin
								if (32'(lvl_q) + 1 < MAX_DEPTH) begin
									lvl_q <= lvl_q + 1'b1;
								end else begin
									stop_q <= 1'b1;
									if (err_q == iee_pkg::ERR_NONE) err_q <= iee_pkg::ERR_DEEP;
								end
							end
							iee_pkg::CH_CLOSE: begin
								if (lvl_q == '0) begin
									stop_q <= 1'b1;
								end else begin
									opnd_q  <= frame_val;
									lvl_q   <= lvl_q - 1'b1;
									close_q <= 1'b1;
								end
							end
							iee_pkg::CH_MUL, iee_pkg::CH_DIV: begin
								if (!has_t) begin
									stop_q <= 1'b1;
									if (err_q == iee_pkg::ERR_NONE) err_q <= iee_pkg::ERR_NOLEFT;
								end
							end
							default: ;
						endcase
					end
					// the last byte has been handled; later pushes come from the fold
					if (last_q) ch_q <= 8'h00;
				end
				iee_pkg::ST_FINISH: begin
					if (!stop_q && num_act_q) begin
						opnd_q    <= num_q;
						num_q     <= '0;
						num_act_q <= 1'b0;
					end
					ch_q <= 8'h00;
				end
				iee_pkg::ST_FOLD: begin
					if (last_q && !stop_q && lvl_q != '0) begin
						opnd_q  <= frame_val;
						lvl_q   <= lvl_q - 1'b1;
						close_q <= 1'b1;
					end
				end
				iee_pkg::ST_RESULT: begin
					res_value_q <= (err_q == iee_pkg::ERR_NONE) ? frame_val : '0;
					res_err_q   <= err_q;
					res_vld_q   <= 1'b1;
				end
				iee_pkg::ST_CLEAR: begin
					num_q     <= '0;
					num_act_q <= 1'b0;
					lvl_q     <= '0;
					stop_q    <= 1'b0;
					err_q     <= iee_pkg::ERR_NONE;
					close_q   <= 1'b0;
					last_q    <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- rtl/iee_checker.sv -----
//------------------------------------------------------------------------------
// iee_checker: port-level checks of the evaluator
// Watches the two channels and attaches to the top level by bind.
//------------------------------------------------------------------------------
module iee_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [33:0] out_data
);
	// a result beat carrying an error shows a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[1:0] != 2'd0 |-> out_data[33:2] == 32'd0)
		else $error("error result with nonzero value");

	// no byte is taken while a result waits
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while result pending");

	// after a byte is taken the block is busy the next cycle
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped under stall");
endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
);
